// ----- hw/rtl/rcl_pkg.sv -----
// Shared types, constants and helper functions for the row centroid line follower.
package rcl_pkg;

	localparam int PIX_W   = 8;
	localparam int MOTOR_W = 9;
	localparam int COUNT_W = 9;
	localparam int SUM_W   = 16;
	localparam int PROD_W  = 26;
	localparam int CNT_W   = 4;

	// result kinds
	localparam logic [1:0] KIND_THRESHOLD = 2'd0;
	localparam logic [1:0] KIND_DRIVE     = 2'd1;
	localparam logic [1:0] KIND_REVERSE   = 2'd2;
	localparam logic [1:0] KIND_LINE_END  = 2'd3;

	// row kinds
	localparam logic OP_CALIBRATE = 1'b0;
	localparam logic OP_TRACK     = 1'b1;

	// register indexes
	localparam logic [1:0] REG_GAIN  = 2'd0;
	localparam logic [1:0] REG_SPEED = 2'd1;
	localparam logic [1:0] REG_END   = 2'd2;

	localparam logic [7:0]         GAIN_RST  = 8'd72;
	localparam logic signed [8:0]  SPEED_RST = -9'sd55;
	localparam logic [8:0]         END_RST   = 9'd310;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic div_start;
		logic div_step;
		logic mul_load;
		logic fin_load;
	} rcl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_div;
		logic div_last;
		logic out_busy;
	} rcl_stat_t;

	// clamp a 9 bit signed value to +-255
	function automatic logic signed [MOTOR_W-1:0] sat_speed(logic signed [MOTOR_W-1:0] v);
		logic signed [MOTOR_W-1:0] r;
		r = v;
		if (v < -9'sd255) r = -9'sd255;
		return r;
	endfunction

	// divide by 256 toward zero, then clamp to +-255
	function automatic logic signed [MOTOR_W-1:0] motor_of(logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-9:0] q;
		logic signed [MOTOR_W-1:0] r;
		q = v[PROD_W-1:8];
		if (v[PROD_W-1] && (v[7:0] != 8'd0)) q = q + 18'sd1;
		if (q > 18'sd255) r = 9'sd255;
		else if (q < -18'sd255) r = -9'sd255;
		else r = q[MOTOR_W-1:0];
		return r;
	endfunction

endpackage

// ----- hw/rtl/rcl_in_if.sv -----
// Pixel input channel: one pixel item per handshake.
interface rcl_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] pixel;
	logic       last;

	modport source (output valid, output op, output pixel, output last, input ready);
	modport sink (input valid, input op, input pixel, input last, output ready);
endinterface

// ----- hw/rtl/rcl_out_if.sv -----
// Result output channel: one outcome item per row.
interface rcl_out_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic signed [8:0] left_motor;
	logic signed [8:0] right_motor;
	logic [7:0]        threshold_out;

	modport source (output valid, output kind, output left_motor, output right_motor,
		output threshold_out, input ready);
	modport sink (input valid, input kind, input left_motor, input right_motor,
		input threshold_out, output ready);
endinterface

// ----- hw/rtl/rcl_regs.sv -----
// APB register file: gain, drive speed and line end count.
module rcl_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  gain_q8,
	output logic signed [8:0] drive_speed,
	output logic [8:0]  end_count
);
	import rcl_pkg::*;

	logic [7:0]        gain_q;
	logic signed [8:0] speed_q;
	logic [8:0]        end_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			speed_q <= SPEED_RST;
			end_q   <= END_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_GAIN:  gain_q  <= pwdata[7:0];
				REG_SPEED: speed_q <= pwdata[8:0];
				REG_END:   end_q   <= pwdata[8:0];
				default:   ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[3:2])
			REG_GAIN:  prdata = {24'd0, gain_q};
			REG_SPEED: prdata = 32'(speed_q);
			REG_END:   prdata = {23'd0, end_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign gain_q8     = gain_q;
	assign drive_speed = speed_q;
	assign end_count   = end_q;
endmodule

// ----- hw/rtl/rcl_ctrl.sv -----
// Controller: pixel intake, serial divide, multiply and result hand-off sequencing.
module rcl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	input  logic              pix_last,
	output logic              pix_ready,
	input  rcl_pkg::rcl_stat_t stat,
	output rcl_pkg::rcl_cmd_t  cmd
);
	import rcl_pkg::*;

	localparam logic [1:0] ST_ACC = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_MUL = 2'd2;
	localparam logic [1:0] ST_FIN = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       accept;

	// a last pixel waits while the previous result is still pending
	assign pix_ready = (state_q == ST_ACC) && !(pix_last && stat.out_busy);
	assign accept    = pix_valid && pix_ready;

	always_comb begin
		state_n       = state_q;
		cmd           = '0;
		cmd.accept    = accept;
		case (state_q)
			ST_ACC: begin
				if (accept && stat.needs_div) begin
					cmd.div_start = 1'b1;
					state_n       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_n = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_n      = ST_FIN;
			end
			ST_FIN: begin
				if (!stat.out_busy) begin
					cmd.fin_load = 1'b1;
					state_n      = ST_ACC;
				end
			end
			default: state_n = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_n;
		end
	end
endmodule

// ----- hw/rtl/rcl_dp.sv -----
// Datapath: row accumulators, threshold, serial divider, gain multiply, result register.
module rcl_dp #(
	parameter int ROW_WIDTH = 320
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op,
	input  logic [7:0]        pixel,
	input  logic              last,
	input  logic              out_ready,
	input  logic [7:0]        gain_q8,
	input  logic signed [8:0] drive_speed,
	input  logic [8:0]        end_count,
	input  rcl_pkg::rcl_cmd_t  cmd,
	output rcl_pkg::rcl_stat_t stat,
	output logic              out_valid,
	output logic [1:0]        kind,
	output logic signed [8:0] left_motor,
	output logic signed [8:0] right_motor,
	output logic [7:0]        threshold_out
);
	import rcl_pkg::*;

	localparam int POS_W = (ROW_WIDTH > 2) ? $clog2(ROW_WIDTH) : 1;
	localparam int OFF_W = POS_W + 1;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(ROW_WIDTH - 1);
	localparam logic signed [OFF_W-1:0] HALF = OFF_W'(ROW_WIDTH / 2);
	localparam logic [COUNT_W-1:0] LIT_MAX = '1;

	// row state
	logic [PIX_W-1:0]          thr_q, max_q, min_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0]        lit_q;
	logic [POS_W-1:0]          pos_q;

	// next-row values including the current pixel
	logic [PIX_W-1:0]          max_n, min_n, thr_cal;
	logic signed [SUM_W-1:0]   sum_n, sum_sat;
	logic signed [SUM_W+1:0]   sum_wide;
	logic signed [OFF_W-1:0]   off;
	logic [COUNT_W-1:0]        lit_n;
	logic                      px_lit;
	logic [SUM_W-1:0]          sum_abs;

	// divider and multiplier
	logic [SUM_W-1:0]          dvd_q;
	logic [COUNT_W-1:0]        dvs_q, rem_q;
	logic                      neg_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [COUNT_W:0]          trial;
	logic                      ge;
	logic signed [SUM_W:0]     mean;
	logic signed [PROD_W-1:0]  prod_q, base;

	// result register
	logic                      vld_q;
	logic [1:0]                kind_q;
	logic signed [MOTOR_W-1:0] left_q, right_q;
	logic [PIX_W-1:0]          thro_q;

	always_comb begin
		px_lit   = pixel > thr_q;
		max_n    = (op == OP_CALIBRATE && pixel > max_q) ? pixel : max_q;
		min_n    = (op == OP_CALIBRATE && pixel < min_q) ? pixel : min_q;
		thr_cal  = PIX_W'((9'(max_n) + 9'(min_n)) >> 1);
		off      = $signed({1'b0, pos_q}) - HALF;
		sum_wide = 18'(sum_q) + 18'(off);
		if (sum_wide > 18'sd32767) sum_sat = 16'sh7FFF;
		else if (sum_wide < -18'sd32768) sum_sat = 16'sh8000;
		else sum_sat = sum_wide[SUM_W-1:0];
		sum_n    = (op == OP_TRACK && px_lit) ? sum_sat : sum_q;
		lit_n    = (op == OP_TRACK && px_lit && lit_q != LIT_MAX) ? lit_q + 9'd1 : lit_q;
		sum_abs  = sum_n[SUM_W-1] ? (~sum_n + 16'd1) : sum_n;
	end

	assign stat.needs_div = last && (op == OP_TRACK) && (lit_n != '0) && (lit_n <= end_count);
	assign stat.div_last  = (cnt_q == '1);
	assign stat.out_busy  = vld_q && !out_ready;

	// row accumulators and threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			max_q <= '0;
			min_q <= '1;
			sum_q <= '0;
			lit_q <= '0;
			pos_q <= '0;
		end else if (cmd.accept) begin
			if (last) begin
				if (op == OP_CALIBRATE) thr_q <= thr_cal;
				max_q <= '0;
				min_q <= '1;
				sum_q <= '0;
				lit_q <= '0;
				pos_q <= '0;
			end else begin
				max_q <= max_n;
				min_q <= min_n;
				sum_q <= sum_n;
				lit_q <= lit_n;
				if (pos_q < POS_MAX) pos_q <= pos_q + 1'b1;
			end
		end
	end

	// restoring divide of |offset sum| by lit count, one quotient bit a cycle
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= sum_abs;
			dvs_q <= lit_n;
			neg_q <= sum_n[SUM_W-1];
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? COUNT_W'(trial - {1'b0, dvs_q}) : trial[COUNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// signed mean times gain
	assign mean = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign base = PROD_W'(drive_speed) <<< 8;

	always_ff @(posedge clk) begin
		if (cmd.mul_load) prod_q <= PROD_W'($signed({1'b0, gain_q8})) * PROD_W'(mean);
	end

	// result register: a new result overrides the hand-off of the old one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if ((cmd.accept && last && !stat.needs_div) || cmd.fin_load) begin
			vld_q <= 1'b1;
		end else if (vld_q && out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_load) begin
			kind_q  <= KIND_DRIVE;
			left_q  <= motor_of(base - prod_q);
			right_q <= motor_of(base + prod_q);
			thro_q  <= thr_q;
		end else if (cmd.accept && last && !stat.needs_div) begin
			if (op == OP_CALIBRATE) begin
				kind_q  <= KIND_THRESHOLD;
				left_q  <= '0;
				right_q <= '0;
				thro_q  <= thr_cal;
			end else if (lit_n == '0) begin
				kind_q  <= KIND_REVERSE;
				left_q  <= sat_speed(drive_speed);
				right_q <= sat_speed(drive_speed);
				thro_q  <= thr_q;
			end else begin
				kind_q  <= KIND_LINE_END;
				left_q  <= '0;
				right_q <= '0;
				thro_q  <= thr_q;
			end
		end
	end

	assign out_valid     = vld_q;
	assign kind          = kind_q;
	assign left_motor    = left_q;
	assign right_motor   = right_q;
	assign threshold_out = thro_q;
endmodule

// ----- hw/rtl/row_centroid_line_follower_core.sv -----
// Throughput: one pixel item per cycle within a row while no steering result is in progress;
// other results appear in the cycle after the last pixel. A steering result (drive kind) goes
// through a 16 step serial divider, a multiply and an output state; pixel intake stalls meanwhile.
// A last pixel waits while the previous result has not been taken.
// Reset (arst_n, asynchronous, active low) restores registers and clears the row state.
module row_centroid_line_follower_core #(
	parameter int ROW_WIDTH = 320
) (
	input  logic        clk,
	input  logic        arst_n,
	rcl_in_if.sink      pix,
	rcl_out_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rcl_pkg::*;

	logic [7:0]        gain_q8;
	logic signed [8:0] drive_speed;
	logic [8:0]        end_count;
	rcl_cmd_t          cmd;
	rcl_stat_t         stat;

	rcl_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.gain_q8, .drive_speed, .end_count
	);

	rcl_ctrl u_ctrl (
		.clk, .arst_n,
		.pix_valid (pix.valid),
		.pix_last  (pix.last),
		.pix_ready (pix.ready),
		.stat, .cmd
	);

	rcl_dp #(.ROW_WIDTH(ROW_WIDTH)) u_dp (
		.clk, .arst_n,
		.op            (pix.op),
		.pixel         (pix.pixel),
		.last          (pix.last),
		.out_ready     (res.ready),
		.gain_q8, .drive_speed, .end_count,
		.cmd, .stat,
		.out_valid     (res.valid),
		.kind          (res.kind),
		.left_motor    (res.left_motor),
		.right_motor   (res.right_motor),
		.threshold_out (res.threshold_out)
	);
endmodule

// ----- verif/row_centroid_line_follower_core_test.sv -----
// Self-checking testbench for the row centroid line follower core.
module row_centroid_line_follower_core_test;
	import rcl_pkg::*;

	localparam int ROW_WIDTH   = 320;
	localparam int SETTLE      = 24;      // divider, multiply and output cycles plus margin
	localparam int HOLD_CYCLES = 300;     // long receiver hold-off
	localparam int LIMIT       = 400000;  // watchdog, in clock cycles
	localparam int PHASE_ITEMS = 180;

	// one expected outcome of a row
	typedef struct {
		logic [1:0]        kind;
		logic signed [8:0] left_cmd;
		logic signed [8:0] right_cmd;
		logic [7:0]        thr;
	} outcome_t;

	// Predicts row outcomes from accepted pixel items and checks the results
	class steering_board;
		logic [7:0]        gain;
		logic signed [8:0] speed;
		logic [8:0]        end_lim;
		logic [7:0]        thr;
		logic [7:0]        rmax;
		logic [7:0]        rmin;
		logic signed [15:0] osum;
		logic [8:0]        lit;
		logic [8:0]        pos;
		outcome_t          outcomes_due[$];
		int                errors;

		function new();
			gain    = GAIN_RST;
			speed   = SPEED_RST;
			end_lim = END_RST;
			thr     = 8'd0;
			errors  = 0;
			clear_row();
		endfunction

		function void clear_row();
			rmax = 8'd0;
			rmin = 8'd255;
			osum = 16'sd0;
			lit  = 9'd0;
			pos  = 9'd0;
		endfunction

		function void set_config(logic [7:0] g, logic signed [8:0] s, logic [8:0] e);
			gain    = g;
			speed   = s;
			end_lim = e;
		endfunction

		function int clamp255(int v);
			if (v > 255) return 255;
			if (v < -255) return -255;
			return v;
		endfunction

		// update the row state with one pixel; on the last pixel queue the outcome
		function void note_pixel(logic op, logic [7:0] px, logic last);
			outcome_t o;
			int s;
			int mean;
			int corr;
			if (op == OP_CALIBRATE) begin
				if (px > rmax) rmax = px;
				if (px < rmin) rmin = px;
			end else if (px > thr) begin
				s = int'(osum) + (int'(pos) - ROW_WIDTH / 2);
				if (s > 32767) s = 32767;
				if (s < -32768) s = -32768;
				osum = s[15:0];
				if (lit < 9'd511) lit = lit + 9'd1;
			end
			if (int'(pos) < ROW_WIDTH - 1) pos = pos + 9'd1;
			if (!last) return;

			o.left_cmd  = 9'sd0;
			o.right_cmd = 9'sd0;
			if (op == OP_CALIBRATE) begin
				s = (int'(rmax) + int'(rmin)) / 2;
				thr = s[7:0];
				o.kind = KIND_THRESHOLD;
			end else if (lit == 9'd0) begin
				// nothing lit: reverse kind, both motors at the drive speed
				o.kind = KIND_REVERSE;
				s = clamp255(int'(speed));
				o.left_cmd  = s[8:0];
				o.right_cmd = s[8:0];
			end else if (lit > end_lim) begin
				o.kind = KIND_LINE_END;
			end else begin
				// proportional steering around the base speed
				mean = int'(osum) / int'(lit);
				corr = int'(gain) * mean;
				o.kind = KIND_DRIVE;
				s = clamp255((int'(speed) * 256 - corr) / 256);
				o.left_cmd = s[8:0];
				s = clamp255((int'(speed) * 256 + corr) / 256);
				o.right_cmd = s[8:0];
			end
			o.thr = thr;
			outcomes_due.push_back(o);
			clear_row();
		endfunction

		// compare one accepted result with the oldest expected outcome
		function void check_result(logic [1:0] kind, logic signed [8:0] lm,
			logic signed [8:0] rm, logic [7:0] th);
			outcome_t o;
			if (outcomes_due.size() == 0) begin
				$display("%0t: result with none expected: kind %0d left %0d right %0d thr %0d",
					$time, kind, lm, rm, th);
				errors++;
				return;
			end
			o = outcomes_due.pop_front();
			if (kind !== o.kind) begin
				$display("%0t: kind expected %0d, got %0d", $time, o.kind, kind);
				errors++;
			end
			if (lm !== o.left_cmd) begin
				$display("%0t: left_motor expected %0d, got %0d", $time, o.left_cmd, lm);
				errors++;
			end
			if (rm !== o.right_cmd) begin
				$display("%0t: right_motor expected %0d, got %0d", $time, o.right_cmd, rm);
				errors++;
			end
			if (th !== o.thr) begin
				$display("%0t: threshold_out expected %0d, got %0d", $time, o.thr, th);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	bit          quiet;
	bit          squeeze;
	int          cycles;
	int          phase_sent;

	steering_board board;

	rcl_in_if  pix_ch ();
	rcl_out_if res_ch ();

	row_centroid_line_follower_core #(
		.ROW_WIDTH(ROW_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("row_centroid_line_follower_core_test: errors");
				$finish;
			end
		end
	end

	// result sink: random stalls, one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze) begin
				res_ch.ready = 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
				squeeze = 1'b0;
			end
			if (!quiet && $urandom_range(0, 5) == 0) begin
				res_ch.ready = 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			@(posedge clk);
			if (res_ch.valid)
				board.check_result(res_ch.kind, res_ch.left_motor, res_ch.right_motor,
					res_ch.threshold_out);
		end
	end

	// offer one pixel item; called and returns at a falling edge
	task automatic push_pixel(logic op, logic [7:0] px, logic last);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			pix_ch.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		pix_ch.op    = op;
		pix_ch.pixel = px;
		pix_ch.last  = last;
		pix_ch.valid = 1'b1;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		board.note_pixel(op, px, last);
		phase_sent++;
		@(negedge clk);
	endtask

	// register write: setup then access cycle
	task automatic reg_write(logic [1:0] idx, logic [31:0] data);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {idx, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// wait until every expected outcome is in and the core has settled
	task automatic drain();
		pix_ch.valid = 1'b0;
		while (board.outcomes_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apply_settings(logic [7:0] g, logic signed [8:0] s, logic [8:0] e);
		drain();
		reg_write(REG_GAIN, {24'd0, g});
		reg_write(REG_SPEED, {23'd0, s});
		reg_write(REG_END, {23'd0, e});
		board.set_config(g, s, e);
		phase_sent = 0;
	endtask

	// one row: mostly short, sometimes wide or overlong; tracking rows carry a lit stripe, all lit or none lit
	task automatic random_row(int max_short);
		int        len;
		int        pick;
		int        mode;
		int        w0;
		int        w1;
		int        t;
		logic      op;
		logic      pop;
		logic [7:0] px;
		pick = $urandom_range(0, 31);
		if (pick == 0) len = $urandom_range(300, 360);
		else if (pick <= 3) len = $urandom_range(100, 299);
		else len = $urandom_range(1, max_short);
		op   = ($urandom_range(0, 3) == 0) ? OP_CALIBRATE : OP_TRACK;
		mode = $urandom_range(0, 7);
		w0   = $urandom_range(0, len - 1);
		w1   = $urandom_range(w0, len - 1);
		for (int i = 0; i < len; i++) begin
			pop = op;
			if ($urandom_range(0, 19) == 0) pop = ~op;
			t = int'(board.thr);
			if (pop == OP_CALIBRATE)
				px = 8'($urandom_range(0, 255));
			else if (mode == 1 || (mode >= 2 && i >= w0 && i <= w1))
				px = (t == 255) ? 8'd255 : 8'($urandom_range(t + 1, 255));
			else
				px = 8'($urandom_range(0, t));
			push_pixel(pop, px, i == len - 1);
		end
	endtask

	initial begin
		board        = new();
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = 4'd0;
		pwdata       = 32'd0;
		pix_ch.valid = 1'b0;
		pix_ch.op    = OP_CALIBRATE;
		pix_ch.pixel = 8'd0;
		pix_ch.last  = 1'b0;
		quiet        = 1'b0;
		squeeze      = 1'b0;
		phase_sent   = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows under reset settings, threshold still zero
		push_pixel(OP_TRACK, 8'd0, 1'b1);          // nothing lit: reverse
		push_pixel(OP_TRACK, 8'd255, 1'b1);        // single lit pixel at column zero
		push_pixel(OP_CALIBRATE, 8'd0, 1'b0);
		push_pixel(OP_CALIBRATE, 8'd255, 1'b1);    // threshold 127
		push_pixel(OP_TRACK, 8'd127, 1'b0);        // equal to threshold: not lit
		push_pixel(OP_TRACK, 8'd128, 1'b1);
		push_pixel(OP_CALIBRATE, 8'd255, 1'b1);    // threshold 255
		push_pixel(OP_TRACK, 8'd255, 1'b1);        // nothing can be lit
		push_pixel(OP_TRACK, 8'd200, 1'b0);        // mixed row ending as calibration
		push_pixel(OP_CALIBRATE, 8'd10, 1'b0);
		push_pixel(OP_CALIBRATE, 8'd90, 1'b1);     // threshold 50
		push_pixel(OP_CALIBRATE, 8'd30, 1'b0);     // mixed row ending as tracking
		push_pixel(OP_TRACK, 8'd100, 1'b0);
		push_pixel(OP_TRACK, 8'd255, 1'b1);
		push_pixel(OP_CALIBRATE, 8'd0, 1'b1);      // threshold 0

		// extreme gain and speed; overlong lit row saturates sum and count
		apply_settings(8'd255, 9'sd255, 9'd511);
		for (int i = 0; i < 540; i++) push_pixel(OP_TRACK, 8'd255, i == 539);
		while (phase_sent < PHASE_ITEMS) random_row(24);

		// zero gain, most negative speed, zero end count
		apply_settings(8'd0, -9'sd256, 9'd0);
		while (phase_sent < PHASE_ITEMS) random_row(24);

		// long receiver hold-off while short rows keep coming
		apply_settings(8'd128, -9'sd255, 9'd320);
		squeeze = 1'b1;
		for (int r = 0; r < 20; r++) random_row(3);
		while (phase_sent < PHASE_ITEMS) random_row(24);

		// random settings
		apply_settings(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
			9'($urandom_range(0, 511)));
		while (phase_sent < PHASE_ITEMS) random_row(24);
		apply_settings(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
			9'($urandom_range(0, 511)));
		while (phase_sent < PHASE_ITEMS / 2) random_row(24);

		// back to reset values, no idling on either side
		apply_settings(GAIN_RST, SPEED_RST, END_RST);
		quiet = 1'b1;
		while (phase_sent < PHASE_ITEMS) random_row(24);

		drain();
		if (board.errors == 0 && board.outcomes_due.size() == 0)
			$display("row_centroid_line_follower_core_test: clean");
		else
			$display("row_centroid_line_follower_core_test: errors");
		$finish;
	end

endmodule

// ----- row_centroid_line_follower_core.f -----
hw/rtl/rcl_pkg.sv
hw/rtl/rcl_in_if.sv
hw/rtl/rcl_out_if.sv
hw/rtl/rcl_regs.sv
hw/rtl/rcl_ctrl.sv
hw/rtl/rcl_dp.sv
hw/rtl/row_centroid_line_follower_core.sv
verif/row_centroid_line_follower_core_test.sv
